### sv/pag_pkg.sv
`timescale 1ns / 1ps
package pag_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   localparam int COORD_W    = 32;
   localparam int ENTRY_W    = 3 * COORD_W;
   localparam int ALEN_W     = 20;
   localparam int AHW_W      = 18;
   localparam int CSR_W      = 20;
   localparam int L2_W       = 2 * ALEN_W;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int HALF_W     = MAG_W / 2;
   localparam int PROD_W     = 2 * HALF_W;
   localparam int SQ_W       = 66;
   localparam int ROOT_W     = 33;
   localparam int REM_W      = 36;
   localparam int NUM_W      = ALEN_W + MAG_W;
   localparam int TERM_W     = NUM_W + 1;
   localparam int SUM_W      = 56;

   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   // register indexes on the csr port
   localparam logic CSR_ARROW_LENGTH     = 1'b0;
   localparam logic CSR_ARROW_HALF_WIDTH = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [ADDR_W-1:0]         end_pos;
      logic [ADDR_W-1:0]         earlier;
   } job_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      found;
      logic                      last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADDR, ST_DATA, ST_SQ, ST_CMP, ST_SQRT,
      ST_MUL, ST_DIV, ST_EMIT0, ST_EMIT1, ST_EMIT2, ST_MISS
   } back_state_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      hi_lim = $signed({{(SUM_W-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}});
      lo_lim = $signed({{(SUM_W-COORD_W){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}});
      if (v > hi_lim) begin
         return hi_lim[COORD_W-1:0];
      end else if (v < lo_lim) begin
         return lo_lim[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

### sv/polyline_arrowhead_generator_unit.sv
`timescale 1ns / 1ps
// Polyline arrowhead generator.
// Request side (push/full): one polyline point per request, x/y/z signed
// Q.8, end_of_line on the last point. Points are taken one per cycle while
// full is low, into a 256-entry ring RAM (newest 256 kept).
// On the end point the back end scans earlier points newest first, one
// candidate at a time (RAM read, six partial products on a 16x16 multiplier,
// compare), then a bit-serial square root and five restoring divides
// (skipped at zero length), then three results (two barbs, end point) or one
// not-found result; full stays high until the last result is queued.
// Result side (empty/pop): a 4-entry queue; the back end waits when it is
// full, so a stalled receiver loses nothing.
// CSR: write enable, index (0 arrow length, 1 half width), data; write only
// while idle.
// Reset: ring pointers, point count and queues cleared; CSRs back to 6400
// and 1536. RAM contents are not cleared.
module polyline_arrowhead_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [pag_pkg::COORD_W-1:0]   req_pt_x,
   input  logic signed [pag_pkg::COORD_W-1:0]   req_pt_y,
   input  logic signed [pag_pkg::COORD_W-1:0]   req_pt_z,
   input  logic                                 req_end_of_line,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [pag_pkg::COORD_W-1:0]   rsp_out_x,
   output logic signed [pag_pkg::COORD_W-1:0]   rsp_out_y,
   output logic signed [pag_pkg::COORD_W-1:0]   rsp_out_z,
   output logic                                 rsp_found,
   output logic                                 rsp_last_out,
   input  logic                                 csr_write,
   input  logic                                 csr_index,
   input  logic [pag_pkg::CSR_W-1:0]            csr_wdata
);
   import pag_pkg::*;

   logic [ALEN_W-1:0]  alen_ff, alen_in;
   logic [AHW_W-1:0]   ahw_ff, ahw_in;
   logic               job_valid, job_take, back_busy;
   job_type            job;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic               fifo_full, fifo_push;
   rsp_type            fifo_data, head;

   // config registers
   always_comb begin
      alen_in = alen_ff;
      ahw_in  = ahw_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ARROW_LENGTH:     alen_in = csr_wdata[ALEN_W-1:0];
            CSR_ARROW_HALF_WIDTH: ahw_in  = csr_wdata[AHW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alen_ff <= ALEN_W'(6400);
         ahw_ff  <= AHW_W'(1536);
      end else begin
         alen_ff <= alen_in;
         ahw_ff  <= ahw_in;
      end
   end

   // front end: point intake, ring pointers, one-entry job queue
   pag_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pt_x        (req_pt_x),
      .req_pt_y        (req_pt_y),
      .req_pt_z        (req_pt_z),
      .req_end_of_line (req_end_of_line),
      .back_busy       (back_busy),
      .job_take        (job_take),
      .job_valid       (job_valid),
      .job             (job),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata)
   );

   pag_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // back end: scan, root, divides, result formation
   pag_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job              (job),
      .job_take         (job_take),
      .busy             (back_busy),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .alen             (alen_ff),
      .arrow_half_width (ahw_ff),
      .fifo_full        (fifo_full),
      .fifo_push        (fifo_push),
      .fifo_data        (fifo_data)
   );

   pag_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_data),
      .full      (fifo_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_out_x    = head.x;
   assign rsp_out_y    = head.y;
   assign rsp_out_z    = head.z;
   assign rsp_found    = head.found;
   assign rsp_last_out = head.last;
endmodule

### sv/pag_ram.sv
`timescale 1ns / 1ps
module pag_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/pag_front.sv
`timescale 1ns / 1ps
module pag_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [pag_pkg::COORD_W-1:0] req_pt_x,
   input  logic signed [pag_pkg::COORD_W-1:0] req_pt_y,
   input  logic signed [pag_pkg::COORD_W-1:0] req_pt_z,
   input  logic                             req_end_of_line,
   input  logic                             back_busy,
   input  logic                             job_take,
   output logic                             job_valid,
   output pag_pkg::job_type                 job,
   output logic                             ram_we,
   output logic [pag_pkg::ADDR_W-1:0]       ram_waddr,
   output logic [pag_pkg::ENTRY_W-1:0]      ram_wdata
);
   import pag_pkg::*;

   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               job_valid_ff, job_valid_in;
   job_type            job_ff, job_in;
   logic               accept;
   logic [ADDR_W-1:0]  wp_next;
   logic [ADDR_W-1:0]  earlier_now;

   assign req_full = job_valid_ff | back_busy;
   assign accept   = req_push & ~req_full;

   assign wp_next     = (wp_ff == ADDR_W'(MAX_POINTS - 1)) ? '0 : wp_ff + 1'b1;
   // points before the end one, capped at one less than the ring size
   assign earlier_now = (count_ff < COUNT_W'(MAX_POINTS)) ? count_ff[ADDR_W-1:0]
                                                          : ADDR_W'(MAX_POINTS - 1);

   always_comb begin
      wp_in        = wp_ff;
      count_in     = count_ff;
      job_valid_in = job_valid_ff & ~job_take;
      job_in       = job_ff;
      if (accept) begin
         if (req_end_of_line) begin
            wp_in          = '0;
            count_in       = '0;
            job_valid_in   = 1'b1;
            job_in.x       = req_pt_x;
            job_in.y       = req_pt_y;
            job_in.z       = req_pt_z;
            job_in.end_pos = wp_ff;
            job_in.earlier = earlier_now;
         end else begin
            wp_in = wp_next;
            if (count_ff < COUNT_W'(MAX_POINTS)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         count_ff     <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign ram_we    = accept;
   assign ram_waddr = wp_ff;
   assign ram_wdata = {req_pt_x, req_pt_y, req_pt_z};
endmodule

### sv/pag_back.sv
`timescale 1ns / 1ps
module pag_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  pag_pkg::job_type             job,
   output logic                         job_take,
   output logic                         busy,
   output logic [pag_pkg::ADDR_W-1:0]   ram_raddr,
   input  logic [pag_pkg::ENTRY_W-1:0]  ram_rdata,
   input  logic [pag_pkg::ALEN_W-1:0]   alen,
   input  logic [pag_pkg::AHW_W-1:0]    arrow_half_width,
   input  logic                         fifo_full,
   output logic                         fifo_push,
   output pag_pkg::rsp_type             fifo_data
);
   import pag_pkg::*;

   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_MID  = 2'd1;
   localparam logic [1:0] SH_TOP  = 2'd2;
   localparam logic [2:0] SQ_LAST  = 3'd6;
   localparam logic [2:0] SEL_AX   = 3'd0;
   localparam logic [2:0] SEL_AY   = 3'd1;
   localparam logic [2:0] SEL_AZ   = 3'd2;
   localparam logic [2:0] SEL_SX   = 3'd3;
   localparam logic [2:0] SEL_SY   = 3'd4;
   localparam logic [5:0] SQRT_LAST = 6'(ROOT_W - 1);
   localparam logic [5:0] DIV_LAST  = 6'(NUM_W - 1);

   back_state_type            state_ff, state_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in, pos_prev;
   logic [ADDR_W-1:0]         left_ff, left_in;
   logic signed [COORD_W-1:0] ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic [L2_W-1:0]           l2_ff, l2_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [MAG_W-1:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic [2:0]                step_ff, step_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [1:0]                sh_ff, sh_in;
   logic [SQ_W-1:0]           acc_ff, acc_in, shifted;
   logic [SQ_W-1:0]           rad_ff, rad_in;
   logic [REM_W-1:0]          rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [5:0]                cnt_ff, cnt_in;
   logic [NUM_W-1:0]          num_ff, num_in, qnum;
   logic [ROOT_W-1:0]         drem_ff, drem_in;
   logic                      neg_ff, neg_in;
   logic [2:0]                sel_ff, sel_in;
   logic signed [TERM_W-1:0]  term_ff [5];
   logic signed [TERM_W-1:0]  term_in [5];
   logic signed [TERM_W-1:0]  term_val;
   logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
   logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_z, neg_x, neg_y;
   logic [HALF_W-1:0]         op_a, op_b;
   logic                      sq_ge, d_ge;
   logic [ROOT_W:0]           dr, dr_sub;
   logic signed [DIFF_W-1:0]  mul_d, mul_dn;
   logic [MAG_W-1:0]          mul_mag;
   logic [ALEN_W-1:0]         mul_reg;
   logic signed [SUM_W-1:0]   sx, sy, sz, tax, tay, taz, tsx, tsy;

   assign pos_prev = (pos_ff == '0) ? ADDR_W'(MAX_POINTS - 1) : pos_ff - 1'b1;
   assign rd_x = ram_rdata[3*COORD_W-1:2*COORD_W];
   assign rd_y = ram_rdata[2*COORD_W-1:COORD_W];
   assign rd_z = ram_rdata[COORD_W-1:0];
   assign diff_x = DIFF_W'(ex_ff) - DIFF_W'(rd_x);
   assign diff_y = DIFF_W'(ey_ff) - DIFF_W'(rd_y);
   assign diff_z = DIFF_W'(ez_ff) - DIFF_W'(rd_z);
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;

   // partial products of the two squares, 16x16 each
   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = ax_ff[HALF_W-1:0];     op_b = ax_ff[HALF_W-1:0]; end
         3'd1:    begin op_a = ax_ff[MAG_W-1:HALF_W]; op_b = ax_ff[HALF_W-1:0]; end
         3'd2:    begin op_a = ax_ff[MAG_W-1:HALF_W]; op_b = ax_ff[MAG_W-1:HALF_W]; end
         3'd3:    begin op_a = ay_ff[HALF_W-1:0];     op_b = ay_ff[HALF_W-1:0]; end
         3'd4:    begin op_a = ay_ff[MAG_W-1:HALF_W]; op_b = ay_ff[HALF_W-1:0]; end
         3'd5:    begin op_a = ay_ff[MAG_W-1:HALF_W]; op_b = ay_ff[MAG_W-1:HALF_W]; end
         default: begin op_a = '0;                    op_b = '0; end
      endcase
   end

   always_comb begin
      case (sh_ff)
         SH_NONE: shifted = SQ_W'(prod_ff);
         SH_MID:  shifted = SQ_W'(prod_ff) << (HALF_W + 1);
         SH_TOP:  shifted = SQ_W'(prod_ff) << MAG_W;
         default: shifted = '0;
      endcase
   end

   // one root bit per cycle
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SQ_W-1:SQ_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign sq_ge  = rem_sh >= trial;

   // one quotient bit per cycle
   assign dr     = {drem_ff, num_ff[NUM_W-1]};
   assign d_ge   = dr >= {1'b0, root_ff};
   assign dr_sub = dr - {1'b0, root_ff};
   assign qnum   = {num_ff[NUM_W-2:0], d_ge};
   assign term_val = neg_ff ? -$signed({1'b0, qnum}) : $signed({1'b0, qnum});

   always_comb begin
      case (sel_ff)
         SEL_AX:  mul_d = dx_ff;
         SEL_AY:  mul_d = dy_ff;
         SEL_AZ:  mul_d = dz_ff;
         SEL_SX:  mul_d = dx_ff;
         SEL_SY:  mul_d = dy_ff;
         default: mul_d = '0;
      endcase
   end
   assign mul_dn  = -mul_d;
   assign mul_mag = mul_d[DIFF_W-1] ? mul_dn[MAG_W-1:0] : mul_d[MAG_W-1:0];
   assign mul_reg = (sel_ff < SEL_SX) ? alen : ALEN_W'(arrow_half_width);

   assign sx  = SUM_W'(ex_ff);
   assign sy  = SUM_W'(ey_ff);
   assign sz  = SUM_W'(ez_ff);
   assign tax = SUM_W'(term_ff[SEL_AX]);
   assign tay = SUM_W'(term_ff[SEL_AY]);
   assign taz = SUM_W'(term_ff[SEL_AZ]);
   assign tsx = SUM_W'(term_ff[SEL_SX]);
   assign tsy = SUM_W'(term_ff[SEL_SY]);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      ez_in     = ez_ff;
      l2_in     = l2_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      step_in   = step_ff;
      prod_in   = prod_ff;
      sh_in     = sh_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      drem_in   = drem_ff;
      neg_in    = neg_ff;
      sel_in    = sel_ff;
      for (int k = 0; k < 5; k++) begin
         term_in[k] = term_ff[k];
      end
      job_take  = 1'b0;
      fifo_push = 1'b0;
      fifo_data = '0;
      ram_raddr = pos_prev;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               ex_in    = job.x;
               ey_in    = job.y;
               ez_in    = job.z;
               pos_in   = job.end_pos;
               left_in  = job.earlier;
               l2_in    = alen * alen;
               state_in = (job.earlier == '0) ? ST_MISS : ST_ADDR;
            end
         end
         ST_ADDR: begin
            pos_in   = pos_prev;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            dx_in    = diff_x;
            dy_in    = diff_y;
            dz_in    = diff_z;
            ax_in    = diff_x[DIFF_W-1] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
            ay_in    = diff_y[DIFF_W-1] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
            acc_in   = '0;
            step_in  = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (step_ff != '0) begin
               acc_in = acc_ff + shifted;
            end
            if (step_ff == SQ_LAST) begin
               state_in = ST_CMP;
            end else begin
               prod_in = op_a * op_b;
               case (step_ff)
                  3'd0, 3'd3: sh_in = SH_NONE;
                  3'd1, 3'd4: sh_in = SH_MID;
                  default:    sh_in = SH_TOP;
               endcase
               step_in = step_ff + 1'b1;
            end
         end
         ST_CMP: begin
            if (acc_ff >= SQ_W'(l2_ff)) begin
               rad_in   = acc_ff;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else if (left_ff == ADDR_W'(1)) begin
               state_in = ST_MISS;
            end else begin
               left_in  = left_ff - 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_SQRT: begin
            rem_in  = sq_ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               sel_in   = SEL_AX;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (root_ff == '0) begin
               // zero length: no offsets
               term_in[sel_ff] = '0;
               sel_in   = sel_ff + 1'b1;
               state_in = (sel_ff == SEL_SY) ? ST_EMIT0 : ST_MUL;
            end else begin
               num_in   = mul_reg * mul_mag;
               neg_in   = mul_d[DIFF_W-1];
               drem_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            drem_in = d_ge ? dr_sub[ROOT_W-1:0] : dr[ROOT_W-1:0];
            num_in  = qnum;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               term_in[sel_ff] = term_val;
               sel_in   = sel_ff + 1'b1;
               state_in = (sel_ff == SEL_SY) ? ST_EMIT0 : ST_MUL;
            end
         end
         ST_EMIT0: begin
            fifo_data.x     = sat32(sx - tax + tsy);
            fifo_data.y     = sat32(sy - tay - tsx);
            fifo_data.z     = sat32(sz - taz);
            fifo_data.found = 1'b1;
            fifo_data.last  = 1'b0;
            fifo_push = ~fifo_full;
            if (!fifo_full) begin
               state_in = ST_EMIT1;
            end
         end
         ST_EMIT1: begin
            fifo_data.x     = sat32(sx - tax - tsy);
            fifo_data.y     = sat32(sy - tay + tsx);
            fifo_data.z     = sat32(sz - taz);
            fifo_data.found = 1'b1;
            fifo_data.last  = 1'b0;
            fifo_push = ~fifo_full;
            if (!fifo_full) begin
               state_in = ST_EMIT2;
            end
         end
         ST_EMIT2: begin
            fifo_data.x     = ex_ff;
            fifo_data.y     = ey_ff;
            fifo_data.z     = ez_ff;
            fifo_data.found = 1'b1;
            fifo_data.last  = 1'b1;
            fifo_push = ~fifo_full;
            if (!fifo_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            fifo_data.last = 1'b1;
            fifo_push = ~fifo_full;
            if (!fifo_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pos_ff  <= pos_in;
      left_ff <= left_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      ez_ff   <= ez_in;
      l2_ff   <= l2_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      neg_ff  <= neg_in;
      sel_ff  <= sel_in;
      for (int k = 0; k < 5; k++) begin
         term_ff[k] <= term_in[k];
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

### sv/pag_rsp_fifo.sv
`timescale 1ns / 1ps
module pag_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pag_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output pag_pkg::rsp_type head
);
   import pag_pkg::*;

   rsp_type             mem_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == FCNT_W'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + FCNT_W'(do_push) - FCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head = mem_ff[rd_ff];
endmodule

### test/polyline_arrowhead_generator_unit_tb.sv
`timescale 1ns / 1ps
module polyline_arrowhead_generator_unit_tb;
   import pag_pkg::*;

   // one point request and one emitted point
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               eol;
   } point_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               found;
      logic               last;
   } arrow_pt_type;

   int errors = 0;

   task automatic report(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Arrowhead predictor plus queue of expected points.
   class arrow_scoreboard;
      logic signed [31:0] ring_x [MAX_POINTS];
      logic signed [31:0] ring_y [MAX_POINTS];
      logic signed [31:0] ring_z [MAX_POINTS];
      int unsigned wr_ptr;
      int unsigned kept;
      logic [19:0] alen;
      logic [17:0] ahw;
      arrow_pt_type pending[$];

      function void clear();
         wr_ptr = 0;
         kept = 0;
         alen = 20'd6400;
         ahw = 18'd1536;
         pending.delete();
      endfunction

      function logic [63:0] root66(input logic [65:0] v);
         logic [67:0] rem;
         logic [67:0] trial;
         logic [63:0] res;
         rem = 0;
         res = 0;
         for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {res, 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               res = (res << 1) | 1;
            end else begin
               res = res << 1;
            end
         end
         return res;
      endfunction

      function longint term(input longint r, input longint d, input longint len);
         if (len == 0) return 0;
         return (r * d) / len;
      endfunction

      function logic signed [31:0] clip(input longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void push_pt(input longint x, input longint y, input longint z,
                            input logic f, input logic l);
         arrow_pt_type p;
         p.x = clip(x);
         p.y = clip(y);
         p.z = clip(z);
         p.found = f;
         p.last = l;
         pending.insert(pending.size(), p);
      endfunction

      function void note_point(input point_type p);
         int unsigned endpos;
         int unsigned pos;
         longint ex, ey, ez, dx, dy, dz, len;
         logic [65:0] sq;
         logic [65:0] lim;
         logic [65:0] mx, my;
         longint tax, tay, taz, tsx, tsy;
         bit hit;
         endpos = wr_ptr;
         ring_x[endpos] = p.x;
         ring_y[endpos] = p.y;
         ring_z[endpos] = p.z;
         wr_ptr = (endpos + 1) % MAX_POINTS;
         if (kept < MAX_POINTS) kept++;
         if (!p.eol) return;
         ex = p.x;
         ey = p.y;
         ez = p.z;
         lim = 66'(alen) * 66'(alen);
         pos = endpos;
         hit = 0;
         len = 0;
         dx = 0;
         dy = 0;
         dz = 0;
         for (int i = 0; i < kept - 1; i++) begin
            pos = (pos == 0) ? MAX_POINTS - 1 : pos - 1;
            dx = ex - longint'(ring_x[pos]);
            dy = ey - longint'(ring_y[pos]);
            dz = ez - longint'(ring_z[pos]);
            mx = 66'((dx < 0) ? -dx : dx);
            my = 66'((dy < 0) ? -dy : dy);
            sq = mx * mx + my * my;
            if (sq >= lim) begin
               len = longint'(root66(sq));
               hit = 1;
               break;
            end
         end
         wr_ptr = 0;
         kept = 0;
         if (!hit) begin
            push_pt(0, 0, 0, 1'b0, 1'b1);
            return;
         end
         tax = term(alen, dx, len);
         tay = term(alen, dy, len);
         taz = term(alen, dz, len);
         tsx = term(ahw, dx, len);
         tsy = term(ahw, dy, len);
         push_pt(ex - tax + tsy, ey - tay - tsx, ez - taz, 1'b1, 1'b0);
         push_pt(ex - tax - tsy, ey - tay + tsx, ez - taz, 1'b1, 1'b0);
         push_pt(ex, ey, ez, 1'b1, 1'b1);
      endfunction

      task check_point(input arrow_pt_type got);
         arrow_pt_type w;
         if (pending.size() == 0) begin
            report($sformatf("unexpected point x=%0d", got.x));
            return;
         end
         w = pending.pop_front();
         if (got.x !== w.x) report($sformatf("x got %0d want %0d", got.x, w.x));
         if (got.y !== w.y) report($sformatf("y got %0d want %0d", got.y, w.y));
         if (got.z !== w.z) report($sformatf("z got %0d want %0d", got.z, w.z));
         if (got.found !== w.found)
            report($sformatf("found got %0b want %0b", got.found, w.found));
         if (got.last !== w.last)
            report($sformatf("last got %0b want %0b", got.last, w.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic signed [31:0] req_pt_x = 0;
   logic signed [31:0] req_pt_y = 0;
   logic signed [31:0] req_pt_z = 0;
   logic req_end_of_line = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic rsp_found;
   logic rsp_last_out;
   logic csr_write = 0;
   logic csr_index = CSR_ARROW_LENGTH;
   logic [CSR_W-1:0] csr_wdata = 0;

   always #6 clock = ~clock;

   polyline_arrowhead_generator_unit dut (.*);

   arrow_scoreboard board = new();
   int idle_cycles = 0;
   int burst_left = 0;  // sender: requests left in current burst
   int gap_left = 0;    // sender: idle cycles before next burst
   int stall_mode = 0;  // receiver pattern selector

   // Request and result paths: track accepted pushes, check popped points; count cycles with no progress.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            point_type p;
            p.x = req_pt_x;
            p.y = req_pt_y;
            p.z = req_pt_z;
            p.eol = req_end_of_line;
            board.note_point(p);
         end
         if (rsp_pop && !rsp_empty) begin
            arrow_pt_type r;
            r.x = rsp_out_x;
            r.y = rsp_out_y;
            r.z = rsp_out_z;
            r.found = rsp_found;
            r.last = rsp_last_out;
            board.check_point(r);
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: fails the run when the idle count runs past its limit.
   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver stalls on its own pattern: none, random at two rates, mostly stalled.
   always @(posedge clock) begin
      int c;
      c = $urandom_range(0, 99);
      if (c == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 3) != 0);
         2: rsp_pop <= ($urandom_range(0, 1) != 0);
         default: rsp_pop <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic logic signed [31:0] rand_coord(input int spread);
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff - $urandom_range(0, 3);
         1: return 32'sh80000000 + $urandom_range(0, 3);
         2: return $urandom();
         default: return $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
   endfunction

   // One request; push stays high into the next request of a burst and drops
   // during gaps.
   task automatic send_point(input point_type p);
      while (gap_left > 0) begin
         req_push <= 1'b0;
         gap_left--;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pt_x <= p.x;
      req_pt_y <= p.y;
      req_pt_z <= p.z;
      req_end_of_line <= p.eol;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
   endtask

   task automatic send_xyz(input int x, input int y, input int z, input bit eol);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.eol = eol;
      send_point(p);
   endtask

   // Wait for all points back, then let the back end settle before CSR writes.
   task automatic drain();
      int guard;
      guard = 0;
      req_push <= 1'b0;
      while (board.pending.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3200) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ARROW_LENGTH) board.alen = val[19:0];
      else board.ahw = val[17:0];
      @(posedge clock);
   endtask

   // Polyline of n points with random content; spread scales the steps.
   task automatic send_line(input int n, input int spread);
      int x, y;
      x = $signed($urandom_range(0, 200000)) - 100000;
      y = $signed($urandom_range(0, 200000)) - 100000;
      for (int i = 0; i < n; i++) begin
         point_type p;
         if ($urandom_range(0, 19) == 0) begin
            p.x = rand_coord(spread);
            p.y = rand_coord(spread);
         end else begin
            x += $signed($urandom_range(0, 2 * spread)) - spread;
            y += $signed($urandom_range(0, 2 * spread)) - spread;
            p.x = x;
            p.y = y;
         end
         p.z = rand_coord(spread);
         p.eol = (i == n - 1);
         send_point(p);
      end
   endtask

   initial begin
      logic [19:0] lens[4];
      logic [17:0] widths[4];
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single point line (not found).
      send_xyz(100, 200, 300, 1);
      // short line, far enough back: arrow found
      send_xyz(0, 0, 0, 0);
      send_xyz(25600, 0, 512, 1);
      // all points too close: not found
      send_xyz(10, 10, 0, 0);
      send_xyz(20, 20, 0, 0);
      send_xyz(30, 30, 0, 1);
      // extreme coordinates: saturation of barbs
      send_xyz(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
      send_xyz(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
      send_xyz(32'sh7fffffff, 32'sh80000000, 0, 0);
      send_xyz(32'sh80000000, 32'sh7fffffff, -1, 1);
      // nearest qualifying point is not the newest one
      send_xyz(-9000, 4000, 7, 0);
      send_xyz(0, 0, 0, 0);
      send_xyz(100, 0, 0, 1);
      drain();

      // Zero arrow length: zero distance gives zero direction terms.
      write_reg(CSR_ARROW_LENGTH, CSR_W'(0));
      write_reg(CSR_ARROW_HALF_WIDTH, CSR_W'(153600));
      send_xyz(5, 5, 5, 0);
      send_xyz(5, 5, 9, 1);
      send_xyz(-3, 8, 0, 0);
      send_xyz(-3, 9, 0, 1);
      drain();

      // Store overflow: 300 points, oldest overwritten.
      write_reg(CSR_ARROW_LENGTH, 20'hfffff);
      write_reg(CSR_ARROW_HALF_WIDTH, CSR_W'(18'h3ffff));
      send_line(300, 2000);
      drain();

      // Random phases over several register settings, extremes included.
      lens = '{20'd0, 20'd563200, 20'd6400, 20'hfffff};
      widths = '{18'd153600, 18'd0, 18'd1536, 18'h3ffff};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 4) begin
            write_reg(CSR_ARROW_LENGTH, lens[ph]);
            write_reg(CSR_ARROW_HALF_WIDTH, CSR_W'(widths[ph]));
         end else begin
            write_reg(CSR_ARROW_LENGTH, CSR_W'($urandom_range(0, 20'hfffff)));
            write_reg(CSR_ARROW_HALF_WIDTH, CSR_W'($urandom_range(0, 18'h3ffff)));
         end
         for (int k = 0; k < 3; k++) begin
            int n;
            n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
            send_line(n, ($urandom_range(0, 1) != 0) ? 3000 : 400000);
         end
         drain();
      end

      drain();
      if (errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (board.pending.size() != 0)
            report($sformatf("%0d expected points never arrived", board.pending.size()));
         $display("Verification failed");
      end
      $finish;
   end

endmodule
